FILE: rtl/core/bfpa_pkg.sv
// bfpa_pkg: shared constants, types and the sequencer control store
// for the best-fit partition allocator. No dependencies.
package bfpa_pkg;

    // table geometry
    localparam int PARTITIONS = 16;
    localparam int SIZE_BITS  = 16;

    // item field widths
    localparam int FUNC_W   = 1;
    localparam int IDX_W    = 4;
    localparam int AMOUNT_W = 16;
    localparam int SPACE_W  = 16;
    localparam int CNT_W    = 5;

    localparam int S_TDATA_W = 24;  // index(4), amount(16), zero fill
    localparam int M_TDATA_W = 24;  // granted(1), chosen(4), space(16), zero fill

    // derived widths
    localparam int PART_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int SCAN_W = $clog2(PARTITIONS + 1);
    localparam int CMP_W  = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

    // sequencer steps
    typedef enum logic [2:0] {
        S_FETCH  = 3'd0,
        S_LOAD   = 3'd1,
        S_SCAN   = 3'd2,
        S_COMMIT = 3'd3,
        S_EMIT   = 3'd4
    } t_step;

    // jump conditions
    typedef enum logic [1:0] {
        C_GOTO  = 2'd0,  // always jump to target
        C_FETCH = 2'd1,  // on accept: allocate -> target, load -> next step
        C_SCAN  = 2'd2,  // stay until the scan pointer reaches the limit
        C_EMIT  = 2'd3   // stay until the output register is free
    } t_cond;

    typedef struct packed {
        logic  fetch;
        logic  load;
        logic  scan;
        logic  commit;
        logic  emit;
        t_cond cond;
        t_step target;
    } t_uword;

    // control store
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '0;
        unique case (step)
            S_FETCH: begin
                w.fetch  = 1'b1;
                w.cond   = C_FETCH;
                w.target = S_SCAN;
            end
            S_LOAD: begin
                w.load   = 1'b1;
                w.cond   = C_GOTO;
                w.target = S_EMIT;
            end
            S_SCAN: begin
                w.scan   = 1'b1;
                w.cond   = C_SCAN;
                w.target = S_COMMIT;
            end
            S_COMMIT: begin
                w.commit = 1'b1;
                w.cond   = C_GOTO;
                w.target = S_EMIT;
            end
            S_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_EMIT;
                w.target = S_FETCH;
            end
            default: begin
                w.cond   = C_GOTO;
                w.target = S_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/best_fit_partition_allocator.sv
// Best-fit partition allocator: a free-space table driven by a microcoded sequencer.
// Depends on bfpa_pkg.
//
// The block holds one free-space entry per partition, cleared to zero at reset.
// A load item (tuser 0) writes one entry and is acknowledged with granted 1, the
// index and the stored size; an index beyond the table gives an all-zero result.
// An allocate item (tuser 1) scans entries 0 .. partition_count-1 (count clamped
// to the table size) one per cycle through a single comparator, keeps the
// smallest entry that still holds the request (lowest index on ties), subtracts
// the request from it and reports granted, index and remaining space; if nothing
// fits, the result is all zero and the table is unchanged. One item is worked at
// a time: a load goes through the load and emit steps, an allocate through the
// scan, commit and emit steps, the scan taking one entry per cycle. The result
// waits in an output register, so the next item is taken while it is still held.
// partition_count is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module best_fit_partition_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [bfpa_pkg::CNT_W-1:0]     i_cfg_wr_data,     // partition_count
    // input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bfpa_pkg::S_TDATA_W-1:0] s_axis_tdata,      // [3:0] partition_index, [19:4] amount
    input  logic [bfpa_pkg::FUNC_W-1:0]    s_axis_tuser,      // [0] func
    // result items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bfpa_pkg::M_TDATA_W-1:0] m_axis_tdata       // [0] granted, [4:1] chosen_partition,
                                                              // [20:5] space_left
);
    import bfpa_pkg::*;

    // sequencer
    t_step  r_step;
    t_step  n_step;
    t_uword uw;

    // configuration
    logic [CNT_W-1:0]  r_count;
    logic [SCAN_W-1:0] limit;

    // latched item
    logic [IDX_W-1:0]    r_idx;
    logic [AMOUNT_W-1:0] r_amount;

    // free-space table, one entry read per cycle by the scan
    logic [SIZE_BITS-1:0] r_table [PARTITIONS];

    // scan datapath
    logic [SCAN_W-1:0]    r_ptr;
    logic                 r_found;
    logic [PART_W-1:0]    r_best;
    logic [SIZE_BITS-1:0] r_best_val;
    logic [SIZE_BITS-1:0] have;
    logic                 scan_live;
    logic                 fits;
    logic                 better;

    // pending result and output register
    logic                 r_res_granted;
    logic [IDX_W-1:0]     r_res_part;
    logic [SPACE_W-1:0]   r_res_space;
    logic                 r_out_valid;
    logic                 r_out_granted;
    logic [IDX_W-1:0]     r_out_part;
    logic [SPACE_W-1:0]   r_out_space;

    logic                 in_acc;
    logic                 out_free;
    logic [SIZE_BITS-1:0] remain;

    assign uw = ucode(r_step);

    // clamp the count to the table size
    always_comb begin
        if (int'(r_count) > PARTITIONS) begin
            limit = SCAN_W'(PARTITIONS);
        end else begin
            limit = SCAN_W'(r_count);
        end
    end

    assign s_axis_tready = uw.fetch;
    assign in_acc        = s_axis_tvalid && uw.fetch;
    assign out_free      = !r_out_valid || m_axis_tready;

    // one compare per cycle against the running best
    assign scan_live = r_ptr < limit;
    assign have      = r_table[r_ptr[PART_W-1:0]];
    assign fits      = CMP_W'(have) >= CMP_W'(r_amount);
    assign better    = !r_found || (have < r_best_val);
    assign remain    = r_best_val - SIZE_BITS'(r_amount);

    // next step
    always_comb begin
        n_step = r_step;
        unique case (uw.cond)
            C_GOTO: begin
                n_step = uw.target;
            end
            C_FETCH: begin
                if (in_acc) begin
                    n_step = (s_axis_tuser == FUNC_ALLOC) ? uw.target : t_step'(r_step + 3'd1);
                end
            end
            C_SCAN: begin
                if (!scan_live) begin
                    n_step = uw.target;
                end
            end
            C_EMIT: begin
                if (out_free) begin
                    n_step = uw.target;
                end
            end
            default: begin
                n_step = S_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_FETCH;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_ptr       <= '0;
            for (int i = 0; i < PARTITIONS; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            r_step <= n_step;

            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end

            // fetch: latch the item and arm the scan
            if (uw.fetch) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
                if (in_acc) begin
                    r_idx    <= s_axis_tdata[IDX_W-1:0];
                    r_amount <= s_axis_tdata[IDX_W +: AMOUNT_W];
                end
            end

            // load: write one entry, out-of-range index is dropped
            if (uw.load) begin
                if (int'(r_idx) < PARTITIONS) begin
                    r_table[PART_W'(r_idx)] <= SIZE_BITS'(r_amount);
                    r_res_granted <= 1'b1;
                    r_res_part    <= r_idx;
                    r_res_space   <= SPACE_W'(SIZE_BITS'(r_amount));
                end else begin
                    r_res_granted <= 1'b0;
                    r_res_part    <= '0;
                    r_res_space   <= '0;
                end
            end

            // scan: keep the smallest entry that holds the request
            if (uw.scan && scan_live) begin
                if (fits && better) begin
                    r_found    <= 1'b1;
                    r_best     <= r_ptr[PART_W-1:0];
                    r_best_val <= have;
                end
                r_ptr <= r_ptr + SCAN_W'(1);
            end

            // commit: take the request out of the chosen entry
            if (uw.commit) begin
                if (r_found) begin
                    r_table[r_best] <= remain;
                    r_res_granted   <= 1'b1;
                    r_res_part      <= IDX_W'(r_best);
                    r_res_space     <= SPACE_W'(remain);
                end else begin
                    r_res_granted <= 1'b0;
                    r_res_part    <= '0;
                    r_res_space   <= '0;
                end
            end

            // output register
            if (uw.emit && out_free) begin
                r_out_valid   <= 1'b1;
                r_out_granted <= r_res_granted;
                r_out_part    <= r_res_part;
                r_out_space   <= r_res_space;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_space, r_out_part, r_out_granted});

endmodule

FILE: rtl/core/bfpa_checker.sv
// bfpa_checker: port-level checks on the best-fit partition allocator,
// bound to the top level. Depends on bfpa_pkg.
module bfpa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bfpa_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import bfpa_pkg::*;

    // one item at a time: input closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    // a refused or dropped item reports nothing but zeros
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[20:1] == 20'd0))
        else $error("no-grant result carries data");

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // reset empties the output
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind best_fit_partition_allocator bfpa_checker u_bfpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tb_best_fit_partition_allocator.sv
// testbench for best_fit_partition_allocator: directed and random load/allocate items,
// checked against a best-fit predictor kept in a small scoreboard class.
// depends on bfpa_pkg and the allocator rtl
module tb_best_fit_partition_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bfpa_pkg::*;

    localparam int IDLE_PCT     = 29;    // percent of cycles either side sits idle
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 152;
    localparam int DRAIN_CYCLES = 24;    // covers the longest allocate from accept to result
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side

    // one result item, split into its fields
    typedef struct packed {
        logic               granted;
        logic [IDX_W-1:0]   part;
        logic [SPACE_W-1:0] space;
    } t_grant;

    // best-fit predictor plus the queue of results still owed by the block
    class fit_tracker;
        logic [SIZE_BITS-1:0] free_space [PARTITIONS];
        logic [CNT_W-1:0]     part_count;
        t_grant               owed[$];
        int errors;
        int n_loads;
        int n_grants;
        int n_refusals;

        function new();
            foreach (free_space[i]) free_space[i] = '0;
            part_count = '0;
            errors     = 0;
            n_loads    = 0;
            n_grants   = 0;
            n_refusals = 0;
        endfunction

        function int scan_limit();
            return (part_count > PARTITIONS) ? PARTITIONS : int'(part_count);
        endfunction

        // work out the result of one accepted item and update the table
        function void note_item(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] idx,
                                logic [AMOUNT_W-1:0] amt);
            t_grant g;
            int     best;
            g    = '0;
            best = -1;
            if (func == FUNC_LOAD) begin
                if (idx < PARTITIONS) begin
                    free_space[idx] = amt[SIZE_BITS-1:0];
                    g.granted = 1'b1;
                    g.part    = idx;
                    g.space   = free_space[idx];
                end
                n_loads++;
            end else begin
                // smallest entry that still holds the request, lowest index on ties
                for (int j = 0; j < scan_limit(); j++) begin
                    if (free_space[j] >= amt && (best < 0 || free_space[best] > free_space[j]))
                        best = j;
                end
                if (best >= 0) begin
                    free_space[best] = free_space[best] - amt;
                    g.granted = 1'b1;
                    g.part    = IDX_W'(best);
                    g.space   = free_space[best];
                    n_grants++;
                end else begin
                    n_refusals++;
                end
            end
            owed.push_back(g);
        endfunction

        // compare one result item with the oldest owed result
        function void check_result(logic [M_TDATA_W-1:0] word);
            t_grant want;
            t_grant got;
            got.granted = word[0];
            got.part    = word[4:1];
            got.space   = word[20:5];
            if (owed.size() == 0) begin
                $display("%0t: result with nothing owed, got %h", $time, word);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.granted !== want.granted) begin
                $display("%0t: granted expected %0d actual %0d", $time, want.granted,
                         got.granted);
                errors++;
            end
            if (got.part !== want.part) begin
                $display("%0t: chosen_partition expected %0d actual %0d", $time, want.part,
                         got.part);
                errors++;
            end
            if (got.space !== want.space) begin
                $display("%0t: space_left expected %0d actual %0d", $time, want.space,
                         got.space);
                errors++;
            end
        endfunction
    endclass

    // clock, reset and block ports; the inputs driven here are known from time zero
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;    // [3:0] partition_index, [19:4] amount
    logic [FUNC_W-1:0]    s_axis_tuser = '0;    // [0] func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [0] granted, [4:1] chosen_partition,
                                                // [20:5] space_left

    fit_tracker fits;
    logic       tx_calm = 1'b0;     // sender never idles while set
    logic       rx_calm = 1'b0;     // receiver never stalls while set
    int         quiet_cycles = 0;
    int         settings_seen = 0;

    best_fit_partition_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver: random back-pressure, none while rx_calm is set
    always @(posedge i_clk) begin
        m_axis_tready <= rx_calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor and watchdog: values seen here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // results first, a new item never has its result at the same edge
            if (m_axis_tvalid && m_axis_tready)
                fits.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                fits.note_item(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4]);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // offer one item; called in the time step of a rising edge, returns at the
    // edge where the item is taken
    task automatic push_item(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                             input logic [AMOUNT_W-1:0] amt);
        // random idle cycles ahead of the item
        if (!tx_calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {{(S_TDATA_W - IDX_W - AMOUNT_W){1'b0}}, amt, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold off the sender until every owed result is back, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (fits.owed.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // partition_count write, only while nothing is in flight
    task automatic set_partition_count(input logic [CNT_W-1:0] cnt);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cnt;
        fits.part_count = cnt;
        settings_seen++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // request sizes aimed at the current table: exact fits, off by one, extremes
    function automatic logic [AMOUNT_W-1:0] alloc_amount(int limit);
        logic [AMOUNT_W-1:0] base;
        base = (limit > 0) ? fits.free_space[$urandom_range(limit - 1)]
                           : AMOUNT_W'($urandom);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return base;
            4:       return base + 1'b1;
            5:       return base - 1'b1;
            6, 7:    return AMOUNT_W'($urandom_range(255));
            default: return AMOUNT_W'($urandom);
        endcase
    endfunction

    function automatic logic [AMOUNT_W-1:0] load_amount();
        case ($urandom_range(9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return AMOUNT_W'($urandom_range(1023));
            default:    return AMOUNT_W'($urandom);
        endcase
    endfunction

    initial begin
        int limit;
        int cnt;
        int phase_counts [PHASES];
        phase_counts = '{16, 31, 16, 0, 1, 17, 16, 4, 24, 2, 16, 0};
        fits = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // no partitions in use after reset: nothing can be granted
        push_item(FUNC_ALLOC, 4'd9, 16'd0);
        push_item(FUNC_ALLOC, 4'd0, 16'hFFFF);
        drain_results();
        set_partition_count(5'd16);
        // zero request on an all-empty table picks the lowest index
        push_item(FUNC_ALLOC, 4'd15, 16'd0);
        push_item(FUNC_LOAD, 4'd0, 16'hFFFF);
        push_item(FUNC_LOAD, 4'd15, 16'd100);
        push_item(FUNC_LOAD, 4'd5, 16'd100);
        push_item(FUNC_LOAD, 4'd3, 16'd50);
        // smallest that holds the request
        push_item(FUNC_ALLOC, 4'd0, 16'd1);
        // tie between 5 and 15 goes to the lower index
        push_item(FUNC_ALLOC, 4'd0, 16'd100);
        // full-width request fits only the full entry
        push_item(FUNC_ALLOC, 4'd7, 16'hFFFF);
        push_item(FUNC_ALLOC, 4'd7, 16'hFFFF);
        push_item(FUNC_ALLOC, 4'd0, 16'd0);
        push_item(FUNC_LOAD, 4'd10, 16'hAAAA);
        push_item(FUNC_LOAD, 4'd6, 16'h5555);
        // exact fit beats a larger entry
        push_item(FUNC_ALLOC, 4'd10, 16'h5555);
        drain_results();
        // count above the table size scans the whole table
        set_partition_count(5'd31);
        push_item(FUNC_ALLOC, 4'd0, 16'd100);
        push_item(FUNC_ALLOC, 4'd0, 16'hAAAB);
        drain_results();
        // one partition in use: only entry 0 is seen
        set_partition_count(5'd1);
        push_item(FUNC_ALLOC, 4'd0, 16'd1);
        push_item(FUNC_LOAD, 4'd0, 16'd7);
        push_item(FUNC_ALLOC, 4'd0, 16'd7);
        push_item(FUNC_ALLOC, 4'd0, 16'd0);

        // --- random part, one partition_count setting per phase ---
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            cnt = (p == 7 || p == 9) ? $urandom_range(31) : phase_counts[p];
            set_partition_count(CNT_W'(cnt));
            limit = fits.scan_limit();
            // one phase with no idling on either side
            tx_calm = (p == 2);
            rx_calm = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 35) begin
                    // loads mostly go to partitions that are scanned
                    if (limit > 0 && $urandom_range(9) < 7)
                        push_item(FUNC_LOAD, IDX_W'($urandom_range(limit - 1)),
                                  load_amount());
                    else
                        push_item(FUNC_LOAD, IDX_W'($urandom_range(15)), load_amount());
                end else begin
                    push_item(FUNC_ALLOC, IDX_W'($urandom_range(15)), alloc_amount(limit));
                end
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // wait out every owed result plus the longest allocate
        drain_results();
        $display("covered %0d loads, %0d granted and %0d refused allocations",
                 fits.n_loads, fits.n_grants, fits.n_refusals);
        $display("across %0d partition_count settings with random idle on both sides",
                 settings_seen);
        if (fits.errors == 0 && fits.owed.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bfpa_pkg.sv
rtl/core/best_fit_partition_allocator.sv
rtl/core/bfpa_checker.sv
sim/tb_best_fit_partition_allocator.sv
